// ===== hw/rtl/pvic_pkg.sv =====
// Package for the pump and valve interlock controller.
// Holds the transaction structs, opcode and LED codes, register map and constants.
// No dependencies; every other file imports it.
package pvic_pkg;

  // Timer saturation point, sonar geometry, divide-by-ten constants and toggle run length.
  localparam logic [15:0] TIMER_CEILING = 16'd60000;
  localparam logic [11:0] SONAR_ZERO_MM = 12'd860;
  // 6554 / 2**16 approximates one tenth closely enough for values below 9706.
  localparam logic [12:0] DIV10_RECIP   = 13'd6554;
  localparam int          DIV10_SHIFT   = 16;
  localparam logic [15:0] TOGGLE_RUN_S  = 16'(60 * 180);

  // Register reset values.
  localparam logic [4:0]  HOUR_A_RST      = 5'd7;
  localparam logic [4:0]  HOUR_B_RST      = 5'd19;
  localparam logic [15:0] AUTO_RUN_RST    = 16'd7200;
  localparam logic [15:0] PUMP_MIN_OFF_RST = 16'(45 * 60);
  localparam logic [15:0] PUMP_MIN_ON_RST = 16'd15;
  localparam logic [15:0] PUMP_MAX_ON_RST = 16'(15 * 60);
  localparam logic [15:0] VALVE_MAX_ON_RST = 16'(4 * 60 * 60);

  // Register map: word index, byte address 4*index.
  localparam int          CFG_ADDR_W   = 5;
  localparam logic [2:0]  REG_HOUR_A   = 3'd0;
  localparam logic [2:0]  REG_HOUR_B   = 3'd1;
  localparam logic [2:0]  REG_AUTO_RUN = 3'd2;
  localparam logic [2:0]  REG_MIN_OFF  = 3'd3;
  localparam logic [2:0]  REG_MIN_ON   = 3'd4;
  localparam logic [2:0]  REG_MAX_ON   = 3'd5;
  localparam logic [2:0]  REG_VMAX_ON  = 3'd6;

  // Opcodes of the command transaction.
  localparam logic [2:0]  OP_TICK     = 3'd0;
  localparam logic [2:0]  OP_MIDNIGHT = 3'd1;
  localparam logic [2:0]  OP_AUTO     = 3'd2;
  localparam logic [2:0]  OP_MANUAL   = 3'd3;
  localparam logic [2:0]  OP_TOGGLE   = 3'd4;
  localparam logic [2:0]  OP_FLUSH    = 3'd5;
  localparam logic [2:0]  OP_FILL     = 3'd6;

  // Red LED modes.
  localparam logic [1:0]  RED_OFF   = 2'd0;
  localparam logic [1:0]  RED_ON    = 2'd1;
  localparam logic [1:0]  RED_BLINK = 2'd2;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [4:0]  hour_now;
    logic [5:0]  minute_now;
    logic [5:0]  second_now;
    logic [11:0] distance_mm;
    logic        full_switch;
    logic        well_dry;
    logic [10:0] manual_minutes;
  } cmd_t;

  typedef struct packed {
    logic        valve_open;
    logic        pump_running;
    logic        auto_enabled;
    logic        flushing;
    logic        tank_full_flag;
    logic        well_empty_flag;
    logic [15:0] tank_litres;
    logic [15:0] daily_litres;
    logic [15:0] pump_seconds_today;
    logic        green_led;
    logic [1:0]  red_led;
  } stat_t;

  // Configuration bundle from the register block to the core.
  typedef struct packed {
    logic [4:0]  hour_a;
    logic [4:0]  hour_b;
    logic [15:0] auto_run_s;
    logic [15:0] pump_min_off_s;
    logic [15:0] pump_min_on_s;
    logic [15:0] pump_max_on_s;
    logic [15:0] valve_max_on_s;
  } cfg_t;

endpackage

// ===== hw/rtl/pump_valve_interlock_controller_top.sv =====
// Top level of the pump and valve interlock controller.
// Depends on pvic_pkg, pvic_cfg, pvic_core (which uses pvic_level).
//
//   Port group   Kind         Payload
//   cmd          valid/ready  cmd_t: opcode, clock time, sonar, switches, manual length
//   stat         valid/ready  stat_t: outputs, flags, litres, counters, LED modes
//   APB          psel/penable 7 registers at byte addresses 0..24, pready tied high
//
// Each command transaction is captured in an input register and then processed by
// the core logic once the result register is free, which writes the state and the result
// register. Throughput is one transaction per cycle while stat_ready stays high; stat_valid
// rises when the core steps on the registered command. Synchronous reset restores all defaults.
// A stalled result holds the input register; cmd_ready drops only when both hold
// data and the waiting result is not taken in that cycle.
module pump_valve_interlock_controller_top
  import pvic_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cmd_valid,
  output logic                  cmd_ready,
  input  cmd_t                  cmd,
  output logic                  stat_valid,
  input  logic                  stat_ready,
  output stat_t                 stat,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  cfg_t cfg;
  cmd_t cmd_q;
  logic cmd_q_valid;
  logic step;

  pvic_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Pipeline control: the core steps when the result register is free or draining.
  assign step      = cmd_q_valid && (!stat_valid || stat_ready);
  assign cmd_ready = !cmd_q_valid || step;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_q_valid <= 1'b0;
    end else if (cmd_ready) begin
      cmd_q_valid <= cmd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_valid && cmd_ready) begin
      cmd_q <= cmd;
    end
  end

  // Result valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      stat_valid <= 1'b0;
    end else if (step) begin
      stat_valid <= 1'b1;
    end else if (stat_ready) begin
      stat_valid <= 1'b0;
    end
  end

  pvic_core u_core (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .cmd  (cmd_q),
    .cfg  (cfg),
    .stat (stat)
  );

`ifndef SYNTHESIS
  // An accepted transaction always lands in the input register.
  assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> cmd_q_valid)
    else $error("accepted command not held in input register");

  // A step always leaves a result waiting.
  assert property (@(posedge clk) disable iff (rst)
    step |=> stat_valid)
    else $error("core step produced no result");

  // Green LED is the inverse of the valve state.
  assert property (@(posedge clk) disable iff (rst)
    stat_valid |-> stat.green_led == !stat.valve_open)
    else $error("green LED disagrees with valve state");

  // Red LED shows steady on exactly while the pump runs.
  assert property (@(posedge clk) disable iff (rst)
    stat_valid |-> (stat.red_led == RED_ON) == stat.pump_running)
    else $error("red LED disagrees with pump state");
`endif

endmodule

// ===== hw/rtl/pvic_cfg.sv =====
// APB-style configuration registers of the interlock controller.
// Depends on pvic_pkg for the register map, reset values and cfg_t.
module pvic_cfg
  import pvic_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[CFG_ADDR_W-1:2];

  // Register writes; an index past the last register is dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.hour_a         <= HOUR_A_RST;
      cfg.hour_b         <= HOUR_B_RST;
      cfg.auto_run_s     <= AUTO_RUN_RST;
      cfg.pump_min_off_s <= PUMP_MIN_OFF_RST;
      cfg.pump_min_on_s  <= PUMP_MIN_ON_RST;
      cfg.pump_max_on_s  <= PUMP_MAX_ON_RST;
      cfg.valve_max_on_s <= VALVE_MAX_ON_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_HOUR_A:   cfg.hour_a         <= pwdata[4:0];
        REG_HOUR_B:   cfg.hour_b         <= pwdata[4:0];
        REG_AUTO_RUN: cfg.auto_run_s     <= pwdata[15:0];
        REG_MIN_OFF:  cfg.pump_min_off_s <= pwdata[15:0];
        REG_MIN_ON:   cfg.pump_min_on_s  <= pwdata[15:0];
        REG_MAX_ON:   cfg.pump_max_on_s  <= pwdata[15:0];
        REG_VMAX_ON:  cfg.valve_max_on_s <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read mux.
  always_comb begin
    case (reg_idx)
      REG_HOUR_A:   prdata = {27'd0, cfg.hour_a};
      REG_HOUR_B:   prdata = {27'd0, cfg.hour_b};
      REG_AUTO_RUN: prdata = {16'd0, cfg.auto_run_s};
      REG_MIN_OFF:  prdata = {16'd0, cfg.pump_min_off_s};
      REG_MIN_ON:   prdata = {16'd0, cfg.pump_min_on_s};
      REG_MAX_ON:   prdata = {16'd0, cfg.pump_max_on_s};
      REG_VMAX_ON:  prdata = {16'd0, cfg.valve_max_on_s};
      default:      prdata = 32'd0;
    endcase
  end

endmodule

// ===== hw/rtl/pvic_level.sv =====
// Tank level from the sonar distance: (860 - distance) * 3 / 10, toward zero.
// Depends on pvic_pkg for the sonar zero point and the divide-by-ten reciprocal.
module pvic_level
  import pvic_pkg::*;
(
  input  logic [11:0] distance_mm,
  output logic [15:0] litres
);

  logic        below_zero;
  logic [11:0] mag;
  logic [13:0] mag3;
  logic [25:0] prod;
  logic [9:0]  quot;

  // Work on the magnitude so that the division truncates toward zero.
  assign below_zero = distance_mm > SONAR_ZERO_MM;
  assign mag  = below_zero ? (distance_mm - SONAR_ZERO_MM) : (SONAR_ZERO_MM - distance_mm);
  assign mag3 = {mag, 1'b0} + {2'b00, mag};

  // Divide by ten through a reciprocal multiply; exact for the magnitudes seen here.
  assign prod = 26'({12'd0, mag3} * {13'd0, DIV10_RECIP});
  assign quot = prod[DIV10_SHIFT +: 10];

  assign litres = below_zero ? (16'd0 - {6'd0, quot}) : {6'd0, quot};

endmodule

// ===== hw/rtl/pvic_core.sv =====
// Controller state, per-transaction next-state logic and the result register.
// Depends on pvic_pkg and on pvic_level for the sonar conversion.
module pvic_core
  import pvic_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  step,
  input  cmd_t  cmd,
  input  cfg_t  cfg,
  output stat_t stat
);

  typedef struct packed {
    logic        valve_on;
    logic [15:0] valve_timer;
    logic        pump_on;
    logic [15:0] pump_timer;
    logic [15:0] run_limit_s;
    logic [15:0] start_litres;
    logic        auto_mode;
    logic        flush_mode;
    logic        full_latched;
    logic        dry_latched;
    logic [15:0] level_litres;
    logic [15:0] irrigated_today;
    logic [15:0] pump_on_today;
  } state_t;

  state_t      st;
  state_t      st_next;
  stat_t       stat_next;
  logic [15:0] level_now;
  logic [16:0] manual_s;
  logic        auto_hour;

  pvic_level u_level (
    .distance_mm (cmd.distance_mm),
    .litres      (level_now)
  );

  // Manual run length in seconds: minutes * 64 - minutes * 4, kept to 16 bits.
  assign manual_s  = {cmd.manual_minutes, 6'd0} - {4'd0, cmd.manual_minutes, 2'd0};
  assign auto_hour = (cmd.hour_now == cfg.hour_a || cmd.hour_now == cfg.hour_b)
                     && cmd.minute_now == 6'd0 && cmd.second_now == 6'd0;

  // Next state: the event's actions in their defined order.
  always_comb begin
    st_next = st;
    case (cmd.opcode)
      OP_TICK: begin
        st_next.level_litres = level_now;
        st_next.full_latched = cmd.full_switch;
        st_next.dry_latched  = cmd.well_dry;
        // Scheduled irrigation start.
        if (st_next.auto_mode && auto_hour) begin
          st_next.run_limit_s  = cfg.auto_run_s;
          st_next.start_litres = level_now;
          if (!st_next.valve_on && st_next.valve_timer != 16'd0) begin
            st_next.valve_on    = 1'b1;
            st_next.valve_timer = 16'd0;
          end
        end
        // Refill pump start and stop from the level switches.
        if (!st_next.flush_mode && !(st_next.auto_mode && st_next.valve_on)
            && !cmd.full_switch && !cmd.well_dry && !st_next.pump_on
            && st_next.pump_timer > cfg.pump_min_off_s) begin
          st_next.pump_on    = 1'b1;
          st_next.pump_timer = 16'd0;
        end
        if ((cmd.full_switch || cmd.well_dry) && st_next.pump_on
            && st_next.pump_timer > cfg.pump_min_on_s) begin
          st_next.pump_on    = 1'b0;
          st_next.pump_timer = 16'd0;
        end
        // Run end, timer advance and maximum on-times; all frozen while flushing.
        if (!st_next.flush_mode) begin
          if (st_next.valve_on && st_next.valve_timer > st_next.run_limit_s) begin
            st_next.valve_on        = 1'b0;
            st_next.valve_timer     = 16'd0;
            st_next.irrigated_today = st_next.irrigated_today + st_next.start_litres
                                      - level_now;
          end
          if (st_next.pump_timer < TIMER_CEILING) begin
            st_next.pump_timer = st_next.pump_timer + 16'd1;
          end
          if (st_next.valve_timer < TIMER_CEILING) begin
            st_next.valve_timer = st_next.valve_timer + 16'd1;
          end
          if (st_next.pump_on && st_next.pump_timer > cfg.pump_max_on_s
              && st_next.pump_timer > cfg.pump_min_on_s) begin
            st_next.pump_on    = 1'b0;
            st_next.pump_timer = 16'd0;
          end
          if (st_next.valve_on && st_next.valve_timer > cfg.valve_max_on_s
              && st_next.valve_timer != 16'd0) begin
            st_next.valve_on    = 1'b0;
            st_next.valve_timer = 16'd0;
          end
        end
        if (st_next.pump_on) begin
          st_next.pump_on_today = st_next.pump_on_today + 16'd1;
        end
      end
      OP_MIDNIGHT: begin
        st_next.irrigated_today = 16'd0;
        st_next.pump_on_today   = 16'd0;
      end
      OP_AUTO: begin
        st_next.auto_mode = 1'b1;
      end
      OP_MANUAL: begin
        st_next.auto_mode   = 1'b0;
        st_next.run_limit_s = manual_s[15:0];
        if (!st.valve_on && st.valve_timer != 16'd0) begin
          st_next.valve_on    = 1'b1;
          st_next.valve_timer = 16'd0;
        end
      end
      OP_TOGGLE: begin
        if (!st.valve_on) begin
          st_next.run_limit_s = TOGGLE_RUN_S;
          if (st.valve_timer != 16'd0) begin
            st_next.valve_on    = 1'b1;
            st_next.valve_timer = 16'd0;
          end
        end else if (st.valve_timer != 16'd0) begin
          st_next.valve_on    = 1'b0;
          st_next.valve_timer = 16'd0;
        end
      end
      OP_FLUSH: begin
        st_next.flush_mode = 1'b1;
        if (!st.valve_on && st.valve_timer != 16'd0) begin
          st_next.valve_on    = 1'b1;
          st_next.valve_timer = 16'd0;
        end
        if (st.pump_on && st.pump_timer > cfg.pump_min_on_s) begin
          st_next.pump_on    = 1'b0;
          st_next.pump_timer = 16'd0;
        end
      end
      OP_FILL: begin
        st_next.flush_mode = 1'b0;
        if (st.valve_on && st.valve_timer != 16'd0) begin
          st_next.valve_on    = 1'b0;
          st_next.valve_timer = 16'd0;
        end
      end
      default: ;
    endcase
  end

  // Status fields come from the state after the event.
  always_comb begin
    stat_next.valve_open         = st_next.valve_on;
    stat_next.pump_running       = st_next.pump_on;
    stat_next.auto_enabled       = st_next.auto_mode;
    stat_next.flushing           = st_next.flush_mode;
    stat_next.tank_full_flag     = st_next.full_latched;
    stat_next.well_empty_flag    = st_next.dry_latched;
    stat_next.tank_litres        = st_next.level_litres;
    stat_next.daily_litres       = st_next.irrigated_today;
    stat_next.pump_seconds_today = st_next.pump_on_today;
    stat_next.green_led          = !st_next.valve_on;
    if (st_next.pump_on) begin
      stat_next.red_led = RED_ON;
    end else if (!st_next.full_latched && st_next.dry_latched) begin
      stat_next.red_led = RED_BLINK;
    end else begin
      stat_next.red_led = RED_OFF;
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      st.valve_on        <= 1'b0;
      st.valve_timer     <= TIMER_CEILING;
      st.pump_on         <= 1'b0;
      st.pump_timer      <= TIMER_CEILING;
      st.run_limit_s     <= 16'd0;
      st.start_litres    <= 16'd0;
      st.auto_mode       <= 1'b1;
      st.flush_mode      <= 1'b0;
      st.full_latched    <= 1'b0;
      st.dry_latched     <= 1'b0;
      st.level_litres    <= 16'd0;
      st.irrigated_today <= 16'd0;
      st.pump_on_today   <= 16'd0;
    end else if (step) begin
      st <= st_next;
    end
  end

  // Result register; payload only, validity is tracked by the top level.
  always_ff @(posedge clk) begin
    if (step) begin
      stat <= stat_next;
    end
  end

endmodule
